>>> rtl/gdda_pkg.sv
// Shared types, constants and helpers of the grid DDA ray caster.
// Depends on nothing; every file of the block but gdda_ram imports it.
package gdda_pkg;

    localparam int MAP_DIM   = 64;
    localparam int MAX_RANGE = 100;

    localparam int CELL_W    = $clog2(MAP_DIM);
    localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    // Crossing distances, the scaled parameter and the sample positions.
    localparam int T_W   = 34;
    localparam int DIV_W = 33;
    localparam int DEN_W = 18;
    localparam int S_W   = 35;
    localparam int P_W   = 38;

    localparam logic [T_W-1:0]   SENTINEL_T = T_W'(64'd99999 * 64'd65536);
    localparam logic [T_W-1:0]   LIM_T      = T_W'(64'(MAX_RANGE) * 64'd65536);
    localparam logic [DEN_W-1:0] NEAR_ZERO  = DEN_W'(7);
    localparam logic [16:0]      SCALE_101  = 17'd66191;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_SPARE_2    = 2'd2,
        REG_SPARE_3    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OUT_WALL  = 2'd0,
        OUT_EXIT  = 2'd1,
        OUT_RANGE = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        OP_FIRST_X = 2'd0,
        OP_FIRST_Y = 2'd1,
        OP_STEP_X  = 2'd2,
        OP_STEP_Y  = 2'd3
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MIN,
        S_SCALE,
        S_MUL,
        S_POS,
        S_CHECK,
        S_LOOK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic     map_wr;
        logic     load_ray;
        logic     div_start;
        logic     div_store;
        t_div_op  div_op;
        logic     step_min;
        logic     step_scale;
        logic     step_mul;
        logic     step_pos;
        logic     rd_en;
        logic     capture;
        logic     out_load;
        t_outcome outcome;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic oob;
        logic cell_nz;
        logic in_range;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] cx,
                                                   input logic [CELL_W-1:0] cy);
        return ADDR_W'(int'(cy) * MAP_DIM + int'(cx));
    endfunction

endpackage

>>> rtl/grid_dda_ray_cast.sv
// Top level of the grid DDA ray caster: controller, datapath and checks.
// Depends on gdda_pkg, gdda_ctrl and gdda_dp.

// A load transaction writes one cell of the 64 by 64 wall map and gives no
// result. A cast transaction first forms the two first-crossing distances
// and the two crossing steps in one shared restoring divider that yields
// one quotient bit per cycle; the march then goes through six steps per
// grid crossing (nearest crossing, 1.01 scale multiply, direction multiply,
// position add, bounds check, map read), and a finish state moves the
// result into the output register once that register is free. A result
// waits in the output register until taken, while load transactions
// continue; a new cast is taken as soon as the previous one has placed its
// result in the output register. The wall map powers up undefined, so
// every cell a ray may reach must be loaded first. Map width and height
// are written on the configuration channel, which is always ready; the
// user must write them only while the block is idle, as the block itself
// does not enforce this.
module grid_dda_ray_cast
    import gdda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic [7:0]         i_cell_value,
    input  logic [23:0]        i_ray_start_x,
    input  logic [23:0]        i_ray_start_y,
    input  logic signed [17:0] i_ray_dir_x,
    input  logic signed [17:0] i_ray_dir_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_hit_value,
    output logic [22:0]        o_hit_distance,
    output logic               o_x_side,
    output logic signed [24:0] o_hit_x,
    output logic signed [24:0] o_hit_y,
    output logic [1:0]         o_outcome,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    // Register writes never stall.
    assign o_cfg_ready = 1'b1;

    gdda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gdda_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_wr       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cell_value   (i_cell_value),
        .i_ray_start_x  (i_ray_start_x),
        .i_ray_start_y  (i_ray_start_y),
        .i_ray_dir_x    (i_ray_dir_x),
        .i_ray_dir_y    (i_ray_dir_y),
        .o_hit_value    (o_hit_value),
        .o_hit_distance (o_hit_distance),
        .o_x_side       (o_x_side),
        .o_hit_x        (o_hit_x),
        .o_hit_y        (o_hit_y),
        .o_outcome      (o_outcome)
    );

    // A result that did not end on a wall reports an empty cell.
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome != OUT_WALL) |-> o_hit_value == 8'h00)
        else $error("miss result carries a cell value");

    // A wall hit always carries the nonzero cell that stopped it.
    a_wall_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome == OUT_WALL) |-> o_hit_value != 8'h00)
        else $error("wall hit with empty cell value");

    // Once a cast is taken the input side closes until the march is done.
    a_cast_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind |=> !o_ready)
        else $error("input accepted during a cast");
endmodule

>>> rtl/gdda_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the wall map.
module gdda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/gdda_div.sv
// Restoring divider, one quotient bit per cycle, for the crossing reciprocals.
// Depends on gdda_pkg for the operand widths.
module gdda_div
    import gdda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic [DEN_W-1:0] n_rem;
    logic [DIV_W-1:0] n_q;

    always_comb begin
        shifted = {r_rem, r_q[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        if (!diff[DEN_W+1]) begin
            n_rem = diff[DEN_W-1:0];
            n_q   = {r_q[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[DEN_W-1:0];
            n_q   = {r_q[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

>>> rtl/gdda_dp.sv
// Datapath of the ray caster: ray registers, reciprocal divider, stepping,
// sample arithmetic, wall map and result register. Depends on gdda_pkg,
// gdda_div and gdda_ram.
module gdda_dp
    import gdda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_wr,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic [7:0]         i_cell_value,
    input  logic [23:0]        i_ray_start_x,
    input  logic [23:0]        i_ray_start_y,
    input  logic signed [17:0] i_ray_dir_x,
    input  logic signed [17:0] i_ray_dir_y,
    output logic [7:0]         o_hit_value,
    output logic [22:0]        o_hit_distance,
    output logic               o_x_side,
    output logic signed [24:0] o_hit_x,
    output logic signed [24:0] o_hit_y,
    output logic [1:0]         o_outcome
);
    localparam int G_W = P_W - 16;
    localparam logic signed [P_W-1:0] POS_MIN = -P_W'(64'sd16777216);
    localparam logic signed [P_W-1:0] POS_MAX = P_W'(64'sd16777215);

    logic [6:0] r_map_w, r_map_h;

    logic [23:0]        r_sx, r_sy;
    logic signed [17:0] r_dx, r_dy;
    logic [T_W-1:0]     r_nx, r_ny, r_ox, r_oy, r_t;
    logic               r_xs;
    logic [S_W-1:0]     r_s;
    logic signed [S_W+18:0] r_prod_x, r_prod_y;
    logic signed [P_W-1:0]  r_px, r_py;
    logic [7:0]         r_val;

    logic [7:0]         r_o_value;
    logic [22:0]        r_o_dist;
    logic               r_o_xs;
    logic [24:0]        r_o_x, r_o_y;
    logic [1:0]         r_o_outcome;

    logic [DEN_W-1:0] mag_x, mag_y;
    logic             near_x, near_y;
    logic [16:0]      frac_x, frac_y;
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [T_W+16:0]  scale_prod;
    logic [G_W-1:0]   gx_all, gy_all;
    logic             oob;
    logic [7:0]       rd_data;
    logic             load_ok;

    function automatic logic [DEN_W-1:0] mag_of(input logic signed [17:0] d);
        return d[17] ? DEN_W'(-d) : DEN_W'(d);
    endfunction

    function automatic logic [16:0] frac_of(input logic [23:0] p,
                                            input logic signed [17:0] d);
        if (!d[17] && d != '0) begin
            return 17'h10000 - {1'b0, p[15:0]};
        end
        return {1'b0, p[15:0]};
    endfunction

    function automatic logic [24:0] sat_pos(input logic signed [P_W-1:0] v);
        if (v < POS_MIN) begin
            return POS_MIN[24:0];
        end else if (v > POS_MAX) begin
            return POS_MAX[24:0];
        end
        return v[24:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 7'd64;
            r_map_h <= 7'd64;
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign mag_x  = mag_of(r_dx);
    assign mag_y  = mag_of(r_dy);
    assign near_x = mag_x < NEAR_ZERO;
    assign near_y = mag_y < NEAR_ZERO;
    assign frac_x = frac_of(r_sx, r_dx);
    assign frac_y = frac_of(r_sy, r_dy);

    always_comb begin
        unique case (i_cmd.div_op)
            OP_FIRST_X: begin
                div_dividend = {frac_x, 16'h0000};
                div_divisor  = mag_x;
            end
            OP_FIRST_Y: begin
                div_dividend = {frac_y, 16'h0000};
                div_divisor  = mag_y;
            end
            OP_STEP_X: begin
                div_dividend = DIV_W'(64'h1_0000_0000);
                div_divisor  = (mag_x == '0) ? DEN_W'(1) : mag_x;
            end
            OP_STEP_Y: begin
                div_dividend = DIV_W'(64'h1_0000_0000);
                div_divisor  = (mag_y == '0) ? DEN_W'(1) : mag_y;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    gdda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign scale_prod = r_t * SCALE_101;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ray) begin
            r_sx <= i_ray_start_x;
            r_sy <= i_ray_start_y;
            r_dx <= i_ray_dir_x;
            r_dy <= i_ray_dir_y;
            r_t  <= '0;
            r_xs <= 1'b0;
            r_px <= P_W'(i_ray_start_x);
            r_py <= P_W'(i_ray_start_y);
        end
        if (i_cmd.div_store) begin
            unique case (i_cmd.div_op)
                OP_FIRST_X: r_nx <= near_x ? SENTINEL_T : T_W'(div_quo);
                OP_FIRST_Y: r_ny <= near_y ? SENTINEL_T : T_W'(div_quo);
                OP_STEP_X:  r_ox <= T_W'(div_quo);
                OP_STEP_Y:  r_oy <= T_W'(div_quo);
                default: ;
            endcase
        end
        if (i_cmd.step_min) begin
            // Take the nearer crossing; a tie goes to the horizontal line.
            if (r_nx < r_ny) begin
                r_t  <= r_nx;
                r_nx <= r_nx + r_ox;
                r_xs <= 1'b1;
            end else begin
                r_t  <= r_ny;
                r_ny <= r_ny + r_oy;
                r_xs <= 1'b0;
            end
        end
        if (i_cmd.step_scale) begin
            r_s <= scale_prod[16 +: S_W];
        end
        if (i_cmd.step_mul) begin
            r_prod_x <= r_dx * $signed({1'b0, r_s});
            r_prod_y <= r_dy * $signed({1'b0, r_s});
        end
        if (i_cmd.step_pos) begin
            r_px <= P_W'(r_sx) + P_W'(r_prod_x >>> 16);
            r_py <= P_W'(r_sy) + P_W'(r_prod_y >>> 16);
        end
        if (i_cmd.capture) begin
            r_val <= rd_data;
        end
    end

    assign gx_all = r_px[P_W-1:16];
    assign gy_all = r_py[P_W-1:16];
    assign oob = r_px[P_W-1] || r_py[P_W-1]
              || gx_all >= G_W'(r_map_w) || gx_all >= G_W'(MAP_DIM)
              || gy_all >= G_W'(r_map_h) || gy_all >= G_W'(MAP_DIM);

    assign load_ok = (int'(i_cell_x) < MAP_DIM) && (int'(i_cell_y) < MAP_DIM);

    gdda_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.map_wr && load_ok),
        .i_wr_addr (cell_addr(CELL_W'(i_cell_x), CELL_W'(i_cell_y))),
        .i_wr_data (i_cell_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (cell_addr(r_px[16 +: CELL_W], r_py[16 +: CELL_W])),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_value   <= (i_cmd.outcome == OUT_WALL) ? r_val : 8'h00;
            r_o_dist    <= (r_t > T_W'(23'h7FFFFF)) ? 23'h7FFFFF : r_t[22:0];
            r_o_xs      <= r_xs;
            r_o_x       <= sat_pos(r_px);
            r_o_y       <= sat_pos(r_py);
            r_o_outcome <= i_cmd.outcome;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.oob      = oob;
    assign o_stat.cell_nz  = rd_data != 8'h00;
    assign o_stat.in_range = r_t < LIM_T;

    assign o_hit_value    = r_o_value;
    assign o_hit_distance = r_o_dist;
    assign o_x_side       = r_o_xs;
    assign o_hit_x        = $signed(r_o_x);
    assign o_hit_y        = $signed(r_o_y);
    assign o_outcome      = r_o_outcome;
endmodule

>>> rtl/gdda_ctrl.sv
// Controller of the ray caster: sequences the reciprocals and the march and
// owns the handshakes. Depends on gdda_pkg.
module gdda_ctrl
    import gdda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_kind,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state   r_state, n_state;
    t_div_op  r_op, n_op;
    t_outcome r_outcome, n_outcome;
    logic     r_out_valid, n_out_valid;
    logic     out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_outcome = r_outcome;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_kind) begin
                    n_state = S_DIV_GO;
                    n_op    = OP_FIRST_X;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_op == OP_STEP_Y) begin
                        n_state = S_MIN;
                    end else begin
                        n_state = S_DIV_GO;
                        n_op    = t_div_op'(r_op + 2'd1);
                    end
                end
            end
            S_MIN:   n_state = S_SCALE;
            S_SCALE: n_state = S_MUL;
            S_MUL:   n_state = S_POS;
            S_POS:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.oob) begin
                    n_state   = S_FINISH;
                    n_outcome = OUT_EXIT;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                priority if (i_stat.cell_nz) begin
                    n_state   = S_FINISH;
                    n_outcome = OUT_WALL;
                end else if (i_stat.in_range) begin
                    n_state = S_MIN;
                end else begin
                    n_state   = S_FINISH;
                    n_outcome = OUT_RANGE;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.div_op     = r_op;
        o_cmd.outcome    = r_outcome;
        o_cmd.map_wr     = (r_state == S_IDLE) && i_valid && !i_kind;
        o_cmd.load_ray   = (r_state == S_IDLE) && i_valid && i_kind;
        o_cmd.div_start  = r_state == S_DIV_GO;
        o_cmd.div_store  = (r_state == S_DIV_WAIT) && i_stat.div_done;
        o_cmd.step_min   = r_state == S_MIN;
        o_cmd.step_scale = r_state == S_SCALE;
        o_cmd.step_mul   = r_state == S_MUL;
        o_cmd.step_pos   = r_state == S_POS;
        o_cmd.rd_en      = (r_state == S_CHECK) && !i_stat.oob;
        o_cmd.capture    = r_state == S_LOOK;
        o_cmd.out_load   = (r_state == S_FINISH) && out_free;
        o_ready          = r_state == S_IDLE;
        n_out_valid      = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FIRST_X;
            r_outcome   <= OUT_RANGE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_outcome   <= n_outcome;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
endmodule
